[src/prgbm_pkg.sv]
// shared types and constants for the program bank mapper
package prgbm_pkg;

    localparam int unsigned BankCntW = 7;
    localparam int unsigned BankSelW = 6;
    localparam int unsigned AddrW    = 16;
    localparam int unsigned PageW    = 13;
    localparam int unsigned OffsetW  = 19;
    localparam int unsigned CycleW   = 8;
    localparam int unsigned DataW    = 8;
    localparam int unsigned InTdataW  = 32;
    localparam int unsigned InTuserW  = 2;
    localparam int unsigned OutTdataW = 24;

    localparam logic [BankCntW-1:0] BankCntReset = 7'd8;
    localparam logic [BankCntW-1:0] BankCntMin   = 7'd4;
    localparam logic [BankCntW-1:0] BankCntMax   = 7'd64;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    // address bits 15..13
    typedef enum logic [2:0] {
        RGN_0000 = 3'd0,
        RGN_2000 = 3'd1,
        RGN_4000 = 3'd2,
        RGN_6000 = 3'd3,
        RGN_8000 = 3'd4,
        RGN_A000 = 3'd5,
        RGN_C000 = 3'd6,
        RGN_E000 = 3'd7
    } region_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } ctrl_state_t;

    typedef struct packed {
        logic exec;
    } ctrl_cmd_t;

endpackage

[src/prgbm_ctrl.sv]
// handshake controller for the mapper output register
module prgbm_ctrl
    import prgbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    assign in_ready  = (state_reg == ST_EMPTY) || out_ready;
    assign out_valid = (state_reg == ST_FULL);
    assign cmd.exec  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_EMPTY:
            begin
                if (cmd.exec)
                begin
                    state_next = ST_FULL;
                end
            end
            ST_FULL:
            begin
                if (!cmd.exec && out_ready)
                begin
                    state_next = ST_EMPTY;
                end
            end
            default:
            begin
                state_next = ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/prgbm_dp.sv]
// mapper state, irq counter, address translation and result register
module prgbm_dp
    import prgbm_pkg::*;
#(
    parameter int unsigned IRQ_PERIOD = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctrl_cmd_t            cmd,
    input  logic                 cfg_we,
    input  logic [BankCntW-1:0]  cfg_wdata,
    input  logic [InTuserW-1:0]  req_type,
    input  logic [AddrW-1:0]     cpu_address,
    input  logic [DataW-1:0]     write_data,
    input  logic [CycleW-1:0]    cycle_count,
    output logic [OffsetW-1:0]   rom_offset,
    output logic                 rom_hit,
    output logic                 irq_line
);

    localparam int unsigned AccW = $clog2(IRQ_PERIOD + 1);
    localparam int unsigned SumW = AccW + 1;
    localparam logic [SumW-1:0] PeriodSum = SumW'(IRQ_PERIOD);

    logic [BankCntW-1:0] bank_cnt_reg;
    logic [BankSelW-1:0] bank_sel_reg;
    logic [BankSelW-1:0] bank_sel_next;
    logic                armed_reg;
    logic                armed_next;
    logic [AccW-1:0]     acc_reg;
    logic [AccW-1:0]     acc_next;
    logic                waiting_reg;
    logic                waiting_next;
    logic [OffsetW-1:0]  offset_reg;
    logic [OffsetW-1:0]  offset_next;
    logic                hit_reg;
    logic                hit_next;
    logic                irq_reg;

    logic [BankCntW-1:0] n_used;
    logic [BankCntW-1:0] sel_raw;
    logic [BankCntW-1:0] bank;
    logic [SumW-1:0]     acc_sum;
    region_t             region;
    req_type_t           kind;

    assign region  = region_t'(cpu_address[AddrW-1:PageW]);
    assign kind    = req_type_t'(req_type);
    assign sel_raw = BankCntW'(write_data[2:0]);
    assign acc_sum = SumW'(acc_reg) + SumW'(cycle_count);

    always_comb
    begin
        if (bank_cnt_reg < BankCntMin)
        begin
            n_used = BankCntMin;
        end
        else if (bank_cnt_reg > BankCntMax)
        begin
            n_used = BankCntMax;
        end
        else
        begin
            n_used = bank_cnt_reg;
        end
    end

    always_comb
    begin
        case (region)
            RGN_6000: bank = n_used - 7'd2;
            RGN_8000: bank = n_used - 7'd4;
            RGN_A000: bank = n_used - 7'd3;
            RGN_C000: bank = BankCntW'(bank_sel_reg);
            default:  bank = n_used - 7'd1;
        endcase
    end

    always_comb
    begin
        bank_sel_next = bank_sel_reg;
        armed_next    = armed_reg;
        acc_next      = acc_reg;
        waiting_next  = waiting_reg;
        offset_next   = '0;
        hit_next      = 1'b0;
        case (kind)
            REQ_WRITE:
            begin
                case (region)
                    RGN_8000:
                    begin
                        armed_next   = 1'b0;
                        waiting_next = 1'b0;
                        acc_next     = '0;
                    end
                    RGN_A000:
                    begin
                        armed_next = 1'b1;
                        acc_next   = '0;
                    end
                    RGN_E000:
                    begin
                        // value below 8 and count at least 4: one subtract suffices
                        if (sel_raw >= n_used)
                        begin
                            bank_sel_next = BankSelW'(sel_raw - n_used);
                        end
                        else
                        begin
                            bank_sel_next = BankSelW'(sel_raw);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_TICK:
            begin
                if (armed_reg)
                begin
                    if (acc_sum >= PeriodSum)
                    begin
                        acc_next     = AccW'(IRQ_PERIOD);
                        waiting_next = 1'b1;
                        armed_next   = 1'b0;
                    end
                    else
                    begin
                        acc_next = AccW'(acc_sum);
                    end
                end
            end
            REQ_READ:
            begin
                if (region inside {RGN_6000, RGN_8000, RGN_A000, RGN_C000, RGN_E000})
                begin
                    offset_next = {bank[BankSelW-1:0], cpu_address[PageW-1:0]};
                    hit_next    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_cnt_reg <= BankCntReset;
            bank_sel_reg <= '0;
            armed_reg    <= 1'b0;
            acc_reg      <= '0;
            waiting_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bank_cnt_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                bank_sel_reg <= bank_sel_next;
                armed_reg    <= armed_next;
                acc_reg      <= acc_next;
                waiting_reg  <= waiting_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            offset_reg <= offset_next;
            hit_reg    <= hit_next;
            irq_reg    <= waiting_next;
        end
    end

    assign rom_offset = offset_reg;
    assign rom_hit    = hit_reg;
    assign irq_line   = irq_reg;

endmodule

[src/prg_bank_mapper_with_cycle_irq_core.sv]
// top level of the program bank mapper with cycle interrupt
//
// input stream: one transfer per item; tuser carries the request kind
// (write, cycle tick, read translation), tdata the address, write byte
// and tick cycle count. every item yields exactly one output transfer
// with the rom byte offset, a hit flag for reads at $6000 and above,
// and the interrupt-pending level after the item.
// latency: the result is presented on the cycle after the input
// transfer. throughput: one item per cycle while the receiver takes
// each result, set by the single output register; the next item is
// taken in the same cycle the held result is taken.
// when the receiver stalls, the result is held in the output register
// and s_axis_tready drops until it is taken.
// reset clears the bank select, irq enable, counter and pending flag,
// sets the bank count to 8 and empties the output register.
// cfg_we/cfg_wdata write the bank count; write only while idle.
module prg_bank_mapper_with_cycle_irq_core
    import prgbm_pkg::*;
#(
    parameter int unsigned IRQ_PERIOD = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [BankCntW-1:0]  cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // cpu_address, write_data, cycle_count
    input  logic [InTdataW-1:0]  s_axis_tdata,
    // req_type
    input  logic [InTuserW-1:0]  s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // rom_offset, rom_hit, irq_line, zero fill
    output logic [OutTdataW-1:0] m_axis_tdata
);

    ctrl_cmd_t          cmd;
    logic [OffsetW-1:0] rom_offset;
    logic               rom_hit;
    logic               irq_line;

    prgbm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    prgbm_dp #(
        .IRQ_PERIOD (IRQ_PERIOD)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_type    (s_axis_tuser),
        .cpu_address (s_axis_tdata[15:0]),
        .write_data  (s_axis_tdata[23:16]),
        .cycle_count (s_axis_tdata[31:24]),
        .rom_offset  (rom_offset),
        .rom_hit     (rom_hit),
        .irq_line    (irq_line)
    );

    assign m_axis_tdata = {3'b000, irq_line, rom_hit, rom_offset};

endmodule

[src/prgbm_checker.sv]
// port-level checks for the mapper core and their bind
module prgbm_checker
    import prgbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [OutTdataW-1:0] m_axis_tdata
);

    // every accepted item shows a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after input transfer");

    // an empty output side never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a miss carries a zero offset and zero fill
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[19] |->
            m_axis_tdata[18:0] == 19'd0 && m_axis_tdata[23:21] == 3'd0)
        else $error("nonzero offset on miss");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind prg_bank_mapper_with_cycle_irq_core prgbm_checker u_prgbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[sim/tb_prg_bank_mapper_with_cycle_irq_core.sv]
// testbench for the program bank mapper with cycle interrupt core
`timescale 1ns / 100ps

module tb_prg_bank_mapper_with_cycle_irq_core;
    import prgbm_pkg::*;

    localparam int unsigned IrqPeriod  = 4096;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned SettleCyc  = 4;
    localparam int unsigned MaxPrinted = 50;

    typedef struct packed {
        logic               irq;
        logic               hit;
        logic [OffsetW-1:0] offset;
    } map_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [BankCntW-1:0]  cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // cpu_address, write_data, cycle_count
    logic [InTdataW-1:0]  s_axis_tdata;
    // req_type
    logic [InTuserW-1:0]  s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // rom_offset, rom_hit, irq_line, zero fill
    logic [OutTdataW-1:0] m_axis_tdata;

    // mapper state as the block should hold it
    logic [BankCntW-1:0] bank_cnt;
    logic [BankSelW-1:0] bank_sel;
    logic                irq_en;
    int unsigned         cyc_acc;
    logic                irq_pend;

    map_result_t expected_maps[$];
    int unsigned err_cnt = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    logic        holding = 1'b0;
    event        hold_off_ev;

    prg_bank_mapper_with_cycle_irq_core #(
        .IRQ_PERIOD (IrqPeriod)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

    function automatic map_result_t map_access(req_type_t kind, logic [AddrW-1:0] addr,
                                               logic [DataW-1:0] data,
                                               logic [CycleW-1:0] cyc);
        map_result_t r;
        int unsigned n;
        int unsigned bank;
        region_t     rgn;
        r = '0;
        n = 32'(bank_cnt);
        if (n < 32'(BankCntMin))
            n = 32'(BankCntMin);
        if (n > 32'(BankCntMax))
            n = 32'(BankCntMax);
        rgn = region_t'(addr[AddrW-1:PageW]);
        case (kind)
            REQ_WRITE:
            begin
                case (rgn)
                    RGN_8000:
                    begin
                        irq_en   = 1'b0;
                        irq_pend = 1'b0;
                        cyc_acc  = 0;
                    end
                    RGN_A000:
                    begin
                        irq_en  = 1'b1;
                        cyc_acc = 0;
                    end
                    RGN_E000: bank_sel = BankSelW'(32'(data[2:0]) % n);
                    default: ;
                endcase
            end
            REQ_TICK:
            begin
                if (irq_en)
                begin
                    cyc_acc += 32'(cyc);
                    if (cyc_acc >= IrqPeriod)
                    begin
                        cyc_acc  = IrqPeriod;
                        irq_pend = 1'b1;
                        irq_en   = 1'b0;
                    end
                end
            end
            REQ_READ:
            begin
                if (rgn >= RGN_6000)
                begin
                    case (rgn)
                        RGN_6000: bank = n - 2;
                        RGN_8000: bank = n - 4;
                        RGN_A000: bank = n - 3;
                        RGN_C000: bank = 32'(bank_sel);
                        default:  bank = n - 1;
                    endcase
                    r.offset = OffsetW'((bank << PageW) + 32'(addr[PageW-1:0]));
                    r.hit    = 1'b1;
                end
            end
            default: ;
        endcase
        r.irq = irq_pend;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_cnt < MaxPrinted)
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin
        map_result_t got;
        map_result_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_maps.push_back(map_access(req_type_t'(s_axis_tuser),
                    s_axis_tdata[15:0], s_axis_tdata[23:16], s_axis_tdata[31:24]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(map_result_t)-1:0];
                if (expected_maps.size() == 0)
                    report_mismatch("unexpected transfer", 32'(got), 32'd0);
                else
                begin
                    want = expected_maps.pop_front();
                    if (got.offset !== want.offset)
                        report_mismatch("rom_offset", 32'(got.offset), 32'(want.offset));
                    if (got.hit !== want.hit)
                        report_mismatch("rom_hit", 32'(got.hit), 32'(want.hit));
                    if (got.irq !== want.irq)
                        report_mismatch("irq_line", 32'(got.irq), 32'(want.irq));
                end
            end
        end
    end

    // receiver side
    always @(posedge clk)
        m_axis_tready <= !holding && ($urandom_range(99) >= stall_pct);

    // long receiver hold-off
    initial
    begin
        forever
        begin
            @(hold_off_ev);
            holding <= 1'b1;
            repeat (HoldCycles) @(posedge clk);
            holding <= 1'b0;
        end
    end

    task automatic send_item(req_type_t kind, logic [AddrW-1:0] addr, logic [DataW-1:0] data,
                             logic [CycleW-1:0] cyc);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cyc, data, addr};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (expected_maps.size() != 0)
            @(posedge clk);
        repeat (SettleCyc) @(posedge clk);
    endtask

    task automatic write_bank_count(logic [BankCntW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        bank_cnt  = v;
        @(posedge clk);
    endtask

    function automatic logic [AddrW-1:0] region_addr(region_t r);
        return {r, PageW'($urandom)};
    endfunction

    function automatic logic [CycleW-1:0] tick_cycles();
        if ($urandom_range(1))
            return CycleW'($urandom_range(128, 255));
        return CycleW'($urandom);
    endfunction

    task automatic test_address_map();
        send_item(REQ_READ, 16'h0000, 8'hff, 8'hff);
        send_item(REQ_READ, 16'h5fff, 8'h00, 8'h00);
        send_item(REQ_READ, 16'h6000, 8'h00, 8'h00);
        send_item(REQ_READ, 16'h7fff, 8'h00, 8'h00);
        send_item(REQ_READ, 16'h8000, 8'h00, 8'h00);
        send_item(REQ_READ, 16'h9fff, 8'h00, 8'h00);
        send_item(REQ_READ, 16'ha000, 8'h00, 8'h00);
        send_item(REQ_READ, 16'hbfff, 8'h00, 8'h00);
        send_item(REQ_READ, 16'hc000, 8'h00, 8'h00);
        send_item(REQ_READ, 16'hdfff, 8'h00, 8'h00);
        send_item(REQ_READ, 16'he000, 8'h00, 8'h00);
        send_item(REQ_READ, 16'hffff, 8'h00, 8'h00);
        send_item(REQ_WRITE, 16'he000, 8'hff, 8'h00);
        send_item(REQ_READ, 16'hdfff, 8'h00, 8'h00);
        send_item(REQ_WRITE, 16'hc000, 8'hff, 8'hff);
        send_item(REQ_WRITE, 16'h0000, 8'hff, 8'h00);
        send_item(REQ_WRITE, 16'h7fff, 8'hff, 8'h00);
        send_item(REQ_NONE, 16'hffff, 8'hff, 8'hff);
        send_item(REQ_TICK, 16'h0000, 8'h00, 8'hff);
        send_item(REQ_WRITE, 16'hffff, 8'h05, 8'h00);
        send_item(REQ_READ, 16'hc123, 8'h00, 8'h00);
        send_item(REQ_NONE, 16'h0000, 8'h00, 8'h00);
        wait_results_done();
    endtask

    task automatic test_irq_period();
        send_item(REQ_WRITE, 16'ha000, 8'h00, 8'h00);
        repeat (16) send_item(REQ_TICK, 16'h0000, 8'h00, 8'hff);
        send_item(REQ_TICK, 16'h0000, 8'h00, 8'h0f);
        send_item(REQ_TICK, 16'h0000, 8'h00, 8'h00);
        send_item(REQ_TICK, 16'h0000, 8'h00, 8'h01);
        send_item(REQ_TICK, 16'h0000, 8'h00, 8'hff);
        send_item(REQ_WRITE, 16'hbfff, 8'h00, 8'h00);
        send_item(REQ_TICK, 16'h0000, 8'h00, 8'hff);
        send_item(REQ_WRITE, 16'h9fff, 8'h00, 8'h00);
        send_item(REQ_READ, 16'h8000, 8'h00, 8'h00);
        wait_results_done();
    endtask

    task automatic test_bank_counts();
        logic [BankCntW-1:0] counts[10] = '{7'd0, 7'd3, 7'd4, 7'd5, 7'd7,
                                           7'd63, 7'd64, 7'd65, 7'd127, 7'd8};
        foreach (counts[i])
        begin
            write_bank_count(counts[i]);
            send_item(REQ_READ, 16'hc000, 8'h00, 8'h00);
            send_item(REQ_READ, 16'h7fff, 8'h00, 8'h00);
            send_item(REQ_READ, 16'h9fff, 8'h00, 8'h00);
            send_item(REQ_READ, 16'hbfff, 8'h00, 8'h00);
            send_item(REQ_READ, 16'hffff, 8'h00, 8'h00);
            send_item(REQ_WRITE, 16'he000, 8'hf8 | 8'(i % 8), 8'h00);
            send_item(REQ_READ, 16'hdfff, 8'h00, 8'h00);
            send_item(REQ_WRITE, 16'hffff, 8'h07, 8'h00);
            send_item(REQ_READ, 16'hc000, 8'h00, 8'h00);
            wait_results_done();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        -> hold_off_ev;
        repeat (40)
            send_item(req_type_t'($urandom_range(3)), 16'($urandom), 8'($urandom),
                      8'($urandom));
        wait_results_done();
    endtask

    task automatic test_random_traffic(int unsigned n_items, int unsigned idle,
                                       int unsigned stall);
        int unsigned sent;
        int unsigned burst;
        req_type_t   kind;
        logic [AddrW-1:0] addr;
        send_idle_pct = idle;
        stall_pct     = stall;
        write_bank_count(BankCntW'($urandom));
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 60)
            begin
                // arm, count up with reads mixed in, then maybe acknowledge
                send_item(REQ_WRITE, region_addr(RGN_A000), 8'($urandom), 8'($urandom));
                burst = $urandom_range(15, 50);
                for (int k = 0; k < burst; k++)
                begin
                    if ($urandom_range(99) < 70)
                        send_item(REQ_TICK, 16'($urandom), 8'($urandom), tick_cycles());
                    else
                        send_item(REQ_READ, 16'($urandom), 8'($urandom), 8'($urandom));
                end
                if ($urandom_range(1))
                    send_item(REQ_WRITE, region_addr(RGN_8000), 8'($urandom), 8'($urandom));
                sent += burst + 2;
            end
            else
            begin
                burst = $urandom_range(5, 20);
                for (int k = 0; k < burst; k++)
                begin
                    kind = req_type_t'($urandom_range(3));
                    addr = 16'($urandom);
                    if (kind == REQ_WRITE && $urandom_range(1))
                        addr = region_addr(RGN_E000);
                    send_item(kind, addr, 8'($urandom), 8'($urandom));
                end
                sent += burst;
            end
        end
        wait_results_done();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_WRITE;
        bank_cnt = BankCntReset;
        bank_sel = '0;
        irq_en   = 1'b0;
        cyc_acc  = 0;
        irq_pend = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_address_map();
        test_irq_period();
        test_bank_counts();
        test_backpressure();
        test_random_traffic(220, 0, 0);
        test_random_traffic(220, 70, 0);
        test_random_traffic(220, 0, 70);
        test_random_traffic(220, 30, 30);

        repeat (8) @(posedge clk);
        if (expected_maps.size() != 0)
            report_mismatch("results left over", 32'(expected_maps.size()), 32'd0);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[prg_bank_mapper_with_cycle_irq_core.f]
src/prgbm_pkg.sv
src/prgbm_ctrl.sv
src/prgbm_dp.sv
src/prg_bank_mapper_with_cycle_irq_core.sv
src/prgbm_checker.sv
sim/tb_prg_bank_mapper_with_cycle_irq_core.sv
